@@ design/impedance_admittance_controller_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the admittance controller
// Concurrent checks clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef IMPEDANCE_ADMITTANCE_CONTROLLER_ASSERT_SVH
`define IMPEDANCE_ADMITTANCE_CONTROLLER_ASSERT_SVH

// check a property on every clock edge out of reset
`define IAC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// check that a condition holds in the cycle after a trigger
`define IAC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/iac_pkg.sv @@
// ----------------------------------------------------------------------------
// iac_pkg
// Types, constants and control store of the admittance controller sequencer.
// ----------------------------------------------------------------------------
package iac_pkg;

	localparam int CFG_IDX_W = 3;
	localparam int PC_W      = 5;
	localparam int PROG_LEN  = 20;

	localparam logic [CFG_IDX_W-1:0] REG_INV_MASS  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DAMPING   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STIFFNESS = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_HALF_STEP = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_REVERSE   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_AUTO      = 3'd5;

	localparam logic [31:0] HALF_STEP_RST = 32'd10737418;

	// micro-operations
	localparam logic [2:0] OP_SUB   = 3'd0;
	localparam logic [2:0] OP_ADD   = 3'd1;
	localparam logic [2:0] OP_MUL   = 3'd2;
	localparam logic [2:0] OP_JKIND = 3'd3;
	localparam logic [2:0] OP_JMAN  = 3'd4;
	localparam logic [2:0] OP_OUT   = 3'd5;
	localparam logic [2:0] OP_RST   = 3'd6;
	localparam logic [2:0] OP_END   = 3'd7;

	// operand A sources
	localparam logic [2:0] A_TGT  = 3'd0;
	localparam logic [2:0] A_MPOS = 3'd1;
	localparam logic [2:0] A_MVEL = 3'd2;
	localparam logic [2:0] A_F    = 3'd3;
	localparam logic [2:0] A_ACC  = 3'd4;
	localparam logic [2:0] A_VN   = 3'd5;
	localparam logic [2:0] A_ZERO = 3'd6;

	// operand B sources
	localparam logic [2:0] B_FORCE = 3'd0;
	localparam logic [2:0] B_INPOS = 3'd1;
	localparam logic [2:0] B_INVEL = 3'd2;
	localparam logic [2:0] B_MACC  = 3'd3;
	localparam logic [2:0] B_MVEL  = 3'd4;
	localparam logic [2:0] B_PROD  = 3'd5;

	// destinations
	localparam logic [2:0] D_F  = 3'd0;
	localparam logic [2:0] D_X  = 3'd1;
	localparam logic [2:0] D_V  = 3'd2;
	localparam logic [2:0] D_A  = 3'd3;
	localparam logic [2:0] D_S  = 3'd4;
	localparam logic [2:0] D_VN = 3'd5;
	localparam logic [2:0] D_PN = 3'd6;

	// multiplier coefficient and signal sources
	localparam logic [1:0] C_K    = 2'd0;
	localparam logic [1:0] C_B    = 2'd1;
	localparam logic [1:0] C_INVM = 2'd2;
	localparam logic [1:0] C_H    = 2'd3;

	localparam logic [1:0] G_X = 2'd0;
	localparam logic [1:0] G_V = 2'd1;
	localparam logic [1:0] G_F = 2'd2;
	localparam logic [1:0] G_S = 2'd3;

	localparam logic [PC_W-1:0] ADDR_RST = 5'd18;
	localparam logic [PC_W-1:0] ADDR_END = 5'd19;

	typedef struct packed {
		logic [2:0]      op;
		logic [2:0]      a_sel;
		logic [2:0]      b_sel;
		logic [2:0]      dst;
		logic [1:0]      coef_sel;
		logic [1:0]      sig_sel;
		logic [PC_W-1:0] target;
	} ctrl_word_t;

	function automatic ctrl_word_t mk(input logic [2:0] op, input logic [2:0] a_sel,
		input logic [2:0] b_sel, input logic [2:0] dst, input logic [1:0] coef_sel,
		input logic [1:0] sig_sel, input logic [PC_W-1:0] target);
		ctrl_word_t cw;
		cw.op       = op;
		cw.a_sel    = a_sel;
		cw.b_sel    = b_sel;
		cw.dst      = dst;
		cw.coef_sel = coef_sel;
		cw.sig_sel  = sig_sel;
		cw.target   = target;
		return cw;
	endfunction

	function automatic ctrl_word_t ucode(input logic [PC_W-1:0] addr);
		ctrl_word_t cw;
		unique case (addr)
			5'd0:  cw = mk(OP_JKIND, A_ZERO, B_PROD,  D_F,  C_K,    G_X, ADDR_RST);
			5'd1:  cw = mk(OP_JMAN,  A_ZERO, B_PROD,  D_F,  C_K,    G_X, ADDR_END);
			5'd2:  cw = mk(OP_SUB,   A_TGT,  B_FORCE, D_F,  C_K,    G_X, ADDR_END);
			5'd3:  cw = mk(OP_SUB,   A_MPOS, B_INPOS, D_X,  C_K,    G_X, ADDR_END);
			5'd4:  cw = mk(OP_SUB,   A_MVEL, B_INVEL, D_V,  C_K,    G_X, ADDR_END);
			5'd5:  cw = mk(OP_MUL,   A_ZERO, B_PROD,  D_F,  C_K,    G_X, ADDR_END);
			5'd6:  cw = mk(OP_SUB,   A_F,    B_PROD,  D_F,  C_K,    G_X, ADDR_END);
			5'd7:  cw = mk(OP_MUL,   A_ZERO, B_PROD,  D_F,  C_B,    G_V, ADDR_END);
			5'd8:  cw = mk(OP_SUB,   A_F,    B_PROD,  D_F,  C_K,    G_X, ADDR_END);
			5'd9:  cw = mk(OP_MUL,   A_ZERO, B_PROD,  D_F,  C_INVM, G_F, ADDR_END);
			5'd10: cw = mk(OP_ADD,   A_ZERO, B_PROD,  D_A,  C_K,    G_X, ADDR_END);
			5'd11: cw = mk(OP_ADD,   A_ACC,  B_MACC,  D_S,  C_K,    G_X, ADDR_END);
			5'd12: cw = mk(OP_MUL,   A_ZERO, B_PROD,  D_F,  C_H,    G_S, ADDR_END);
			5'd13: cw = mk(OP_ADD,   A_MVEL, B_PROD,  D_VN, C_K,    G_X, ADDR_END);
			5'd14: cw = mk(OP_ADD,   A_VN,   B_MVEL,  D_S,  C_K,    G_X, ADDR_END);
			5'd15: cw = mk(OP_MUL,   A_ZERO, B_PROD,  D_F,  C_H,    G_S, ADDR_END);
			5'd16: cw = mk(OP_ADD,   A_MPOS, B_PROD,  D_PN, C_K,    G_X, ADDR_END);
			5'd17: cw = mk(OP_OUT,   A_ZERO, B_PROD,  D_F,  C_K,    G_X, ADDR_END);
			5'd18: cw = mk(OP_RST,   A_ZERO, B_PROD,  D_F,  C_K,    G_X, ADDR_END);
			default: cw = mk(OP_END, A_ZERO, B_PROD,  D_F,  C_K,    G_X, ADDR_END);
		endcase
		return cw;
	endfunction

	function automatic logic [31:0] sat33(input logic signed [32:0] v);
		logic [31:0] r;
		if (v[32] != v[31]) begin
			r = v[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

@@ design/iac_if.sv @@
// ----------------------------------------------------------------------------
// iac channel interfaces
// Sample, result and register write channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface iac_sample_if;
	logic               valid;
	logic               ready;
	logic               kind;
	logic signed [31:0] measured_force;
	logic signed [31:0] force_target;
	logic signed [31:0] measured_position;
	logic signed [31:0] measured_velocity;

	modport source (output valid, kind, measured_force, force_target,
		measured_position, measured_velocity, input ready);
	modport sink (input valid, kind, measured_force, force_target,
		measured_position, measured_velocity, output ready);
endinterface

interface iac_result_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] drive_position;
	logic signed [31:0] model_velocity;

	modport source (output valid, drive_position, model_velocity, input ready);
	modport sink (input valid, drive_position, model_velocity, output ready);
endinterface

interface iac_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [iac_pkg::CFG_IDX_W-1:0] index;
	logic [31:0]                   data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

@@ design/impedance_admittance_controller.sv @@
// The step counter walks one control word per cycle, save while the output step waits
// for a free result slot, through one shared 33x32 multiplier.
// No new sample is taken while a program runs; a restart and a sample in manual mode
// end the program without a result, and a waiting result holds the output step.
// Reset: model state cleared, registers at their defaults, result channel empty.
// ----------------------------------------------------------------------------
// impedance_admittance_controller
// Mass-spring-damper admittance law with trapezoidal integration, run by a
// microcoded sequencer over a saturating adder and one multiplier.
// ----------------------------------------------------------------------------
module impedance_admittance_controller #(
	parameter int FRACTION_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	iac_sample_if.sink        sample,
	iac_result_if.source      result,
	iac_cfg_if.sink           cfg
);
	import iac_pkg::*;

	localparam logic [30:0] INV_MASS_RST = 31'(1) << FRACTION_BITS;

	logic [30:0] inv_mass_q, damping_q, stiffness_q;
	logic [31:0] half_step_q;
	logic        reverse_q, auto_q;

	logic [31:0] model_accel_q, model_vel_q, model_pos_q;

	logic        busy_q;
	logic [PC_W-1:0] pc_q;
	ctrl_word_t  cw;

	logic        kind_q;
	logic [31:0] force_q, target_q, mpos_q, mvel_q;
	logic [31:0] f_q, x_q, v_q, acc_q, s_q, vn_q, pn_q;

	logic signed [64:0] prod_q;
	logic               mulh_q;

	logic        out_valid_q;
	logic [31:0] drive_q, vel_out_q;

	logic [31:0]        a_val, b_val, prod_term, alu_res, coef_val, sig_val;
	logic signed [64:0] prod_shift, prod_d;
	logic signed [32:0] alu_sum;
	logic               out_slot;

	assign cw        = ucode(pc_q);
	assign out_slot  = !out_valid_q || result.ready;

	assign sample.ready          = !busy_q;
	assign cfg.ready             = 1'b1;
	assign result.valid          = out_valid_q;
	assign result.drive_position = drive_q;
	assign result.model_velocity = vel_out_q;

	always_comb begin
		unique case (cw.a_sel)
			A_TGT:   a_val = target_q;
			A_MPOS:  a_val = model_pos_q;
			A_MVEL:  a_val = model_vel_q;
			A_F:     a_val = f_q;
			A_ACC:   a_val = acc_q;
			A_VN:    a_val = vn_q;
			default: a_val = '0;
		endcase
	end

	always_comb begin
		prod_shift = prod_q >>> FRACTION_BITS;
		if (mulh_q) begin
			prod_term = prod_q[63:32];
		end else if ((&prod_shift[64:31]) || !(|prod_shift[64:31])) begin
			prod_term = prod_shift[31:0];
		end else begin
			prod_term = prod_shift[64] ? 32'h8000_0000 : 32'h7FFF_FFFF;
		end
	end

	always_comb begin
		unique case (cw.b_sel)
			B_FORCE: b_val = force_q;
			B_INPOS: b_val = mpos_q;
			B_INVEL: b_val = mvel_q;
			B_MACC:  b_val = model_accel_q;
			B_MVEL:  b_val = model_vel_q;
			default: b_val = prod_term;
		endcase
	end

	always_comb begin
		if (cw.op == OP_ADD) begin
			alu_sum = $signed({a_val[31], a_val}) + $signed({b_val[31], b_val});
		end else begin
			alu_sum = $signed({a_val[31], a_val}) - $signed({b_val[31], b_val});
		end
		alu_res = sat33(alu_sum);
	end

	always_comb begin
		unique case (cw.coef_sel)
			C_K:     coef_val = {1'b0, stiffness_q};
			C_B:     coef_val = {1'b0, damping_q};
			C_INVM:  coef_val = {1'b0, inv_mass_q};
			default: coef_val = half_step_q;
		endcase
		unique case (cw.sig_sel)
			G_X:     sig_val = x_q;
			G_V:     sig_val = v_q;
			G_F:     sig_val = f_q;
			default: sig_val = s_q;
		endcase
		prod_d = $signed({1'b0, coef_val}) * $signed(sig_val);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_mass_q  <= INV_MASS_RST;
			damping_q   <= '0;
			stiffness_q <= '0;
			half_step_q <= HALF_STEP_RST;
			reverse_q   <= 1'b0;
			auto_q      <= 1'b0;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				REG_INV_MASS:  inv_mass_q  <= cfg.data[30:0];
				REG_DAMPING:   damping_q   <= cfg.data[30:0];
				REG_STIFFNESS: stiffness_q <= cfg.data[30:0];
				REG_HALF_STEP: half_step_q <= cfg.data;
				REG_REVERSE:   reverse_q   <= cfg.data[0];
				REG_AUTO:      auto_q      <= cfg.data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready) begin
			kind_q   <= sample.kind;
			force_q  <= sample.measured_force;
			target_q <= sample.force_target;
			mpos_q   <= sample.measured_position;
			mvel_q   <= sample.measured_velocity;
		end
		if (busy_q && cw.op == OP_MUL) begin
			prod_q <= prod_d;
			mulh_q <= (cw.coef_sel == C_H);
		end
		if (busy_q && (cw.op == OP_ADD || cw.op == OP_SUB)) begin
			unique case (cw.dst)
				D_F:     f_q  <= alu_res;
				D_X:     x_q  <= alu_res;
				D_V:     v_q  <= alu_res;
				D_A:     acc_q <= alu_res;
				D_S:     s_q  <= alu_res;
				D_VN:    vn_q <= alu_res;
				default: pn_q <= alu_res;
			endcase
		end
		if (busy_q && cw.op == OP_OUT && out_slot) begin
			drive_q   <= reverse_q ? sat33(33'sd0 - $signed({pn_q[31], pn_q})) : pn_q;
			vel_out_q <= vn_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q        <= 1'b0;
			pc_q          <= '0;
			out_valid_q   <= 1'b0;
			model_accel_q <= '0;
			model_vel_q   <= '0;
			model_pos_q   <= '0;
		end else begin
			if (busy_q && cw.op == OP_OUT && out_slot) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			if (!busy_q) begin
				if (sample.valid) begin
					busy_q <= 1'b1;
					pc_q   <= '0;
				end
			end else begin
				unique case (cw.op)
					OP_JKIND: pc_q <= kind_q ? cw.target : pc_q + 1'b1;
					OP_JMAN:  pc_q <= !auto_q ? cw.target : pc_q + 1'b1;
					OP_OUT: begin
						if (out_slot) begin
							model_accel_q <= acc_q;
							model_vel_q   <= vn_q;
							model_pos_q   <= pn_q;
							busy_q        <= 1'b0;
						end
					end
					OP_RST: begin
						model_accel_q <= '0;
						model_vel_q   <= '0;
						model_pos_q   <= mpos_q;
						busy_q        <= 1'b0;
					end
					OP_END: busy_q <= 1'b0;
					default: pc_q <= pc_q + 1'b1;
				endcase
			end
		end
	end

`include "impedance_admittance_controller_assert.svh"

	`IAC_ASSERT(a_no_transfer_busy, busy_q |-> !sample.ready, "sample taken while busy")
	`IAC_ASSERT(a_pc_in_program, busy_q |-> (pc_q < PC_W'(PROG_LEN)), "step counter out of program")
	`IAC_ASSERT(a_result_from_out, $rose(result.valid) |-> $past(busy_q && cw.op == OP_OUT), "result without output step")
	`IAC_ASSERT_NEXT(a_restart_clears, busy_q && cw.op == OP_RST, model_accel_q == '0 && model_vel_q == '0, "restart left motion state")

endmodule
